/* hdl/fwta_pkg.sv */
package fwta_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REMOVED  = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TICK     = 3'd4;

  typedef struct packed {
    logic accept;
    logic load_div;
    logic div_step;
    logic emit;
  } fwta_cmd_t;

  typedef struct packed {
    logic remove_hit;
    logic div_last;
    logic out_free;
  } fwta_sts_t;

endpackage

/* hdl/fwta_ram.sv */
module fwta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hdl/fwta_ctrl.sv */
module fwta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fwta_pkg::fwta_sts_t sts,
  output fwta_pkg::fwta_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.accept   = in_valid && (state_r == S_IDLE);
  assign cmd.load_div = (state_r == S_READ);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.emit     = (state_r == S_EMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.remove_hit ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/fwta_dp.sv */
module fwta_dp #(
  parameter int DEPTH = fwta_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fwta_pkg::fwta_cmd_t cmd,
  output fwta_pkg::fwta_sts_t sts,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic signed [31:0]  out_removed_code,
  output logic [31:0]         out_wait_ticks,
  output logic [31:0]         out_average_wait
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int DW    = fwta_pkg::DATA_W;
  localparam int CNT_W = $clog2(DW);

  logic [PTR_W-1:0]    head_r, tail_r, head_nxt, tail_nxt;
  logic [OCC_W-1:0]    occ_r;
  logic [DW-1:0]       tick_r, sum_r, total_r;
  logic [2:0]          res_status_r;
  logic signed [DW-1:0] res_code_r;
  logic [DW-1:0]       res_wait_r;
  logic [DW-1:0]       rem_r, quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic signed [DW-1:0] out_code_r;
  logic [DW-1:0]       out_wait_r, out_avg_r;

  logic                full, empty, is_insert, is_remove, ram_we;
  logic [2*DW-1:0]     ram_rdata;
  logic [DW-1:0]       wait_val;
  logic [DW:0]         sum_wide, shifted;
  logic                ge;

  assign full      = (occ_r == OCC_W'(DEPTH));
  assign empty     = (occ_r == '0);
  assign is_insert = (in_kind == fwta_pkg::KIND_INSERT);
  assign is_remove = (in_kind == fwta_pkg::KIND_REMOVE);
  assign ram_we    = cmd.accept && is_insert && !full;
  assign head_nxt  = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_nxt  = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  fwta_ram #(
    .WIDTH (2 * DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (tail_r),
    .wdata   ({$unsigned(in_code), tick_r}),
    .re      (cmd.accept),
    .raddr   (head_r),
    .rdata_r (ram_rdata)
  );

  assign wait_val = tick_r - ram_rdata[DW-1:0];
  assign sum_wide = {1'b0, sum_r} + {1'b0, wait_val};
  assign shifted  = {rem_r, quo_r[DW-1]};
  assign ge       = (shifted >= {1'b0, total_r});

  assign sts.remove_hit = is_remove && !empty;
  assign sts.div_last   = (cnt_r == CNT_W'(DW - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      tick_r      <= '0;
      sum_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        unique case (in_kind)
          fwta_pkg::KIND_TICK: begin
            tick_r <= tick_r + 1'b1;
          end
          fwta_pkg::KIND_INSERT: begin
            if (!full) begin
              tail_r <= tail_nxt;
              occ_r  <= occ_r + 1'b1;
              if (total_r != '1) begin
                total_r <= total_r + 1'b1;
              end
            end
          end
          fwta_pkg::KIND_REMOVE: begin
            if (!empty) begin
              head_r <= head_nxt;
              occ_r  <= occ_r - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.load_div) begin
        sum_r <= sum_wide[DW] ? '1 : sum_wide[DW-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_code_r <= '0;
      res_wait_r <= '0;
      unique case (in_kind)
        fwta_pkg::KIND_INSERT: begin
          res_status_r <= full ? fwta_pkg::ST_FULL : fwta_pkg::ST_INSERTED;
        end
        fwta_pkg::KIND_REMOVE: begin
          res_status_r <= empty ? fwta_pkg::ST_EMPTY : fwta_pkg::ST_REMOVED;
        end
        default: begin
          res_status_r <= fwta_pkg::ST_TICK;
        end
      endcase
    end
    if (cmd.load_div) begin
      res_code_r <= $signed(ram_rdata[2*DW-1:DW]);
      res_wait_r <= wait_val;
      rem_r      <= '0;
      quo_r      <= sum_wide[DW] ? '1 : sum_wide[DW-1:0];
      cnt_r      <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? DW'(shifted - {1'b0, total_r}) : shifted[DW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_code_r   <= res_code_r;
      out_wait_r   <= res_wait_r;
      out_avg_r    <= ((res_status_r == fwta_pkg::ST_REMOVED) && (total_r != '0)) ?
                      quo_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_removed_code = out_code_r;
  assign out_wait_ticks   = out_wait_r;
  assign out_average_wait = out_avg_r;

endmodule

/* hdl/fifo_with_wait_time_average.sv */
// A queue of up to DEPTH signed 32-bit codes, each stamped with a tick count that advances on tick
// words. Every input word (tick, insert, remove or unused kind) yields exactly one result word. One
// word is handled at a time: tick, insert and unproductive removes go from acceptance straight to
// the emit state, while a successful remove first passes one RAM read and a 32-step restoring
// divider that forms the average wait. A finished result is held in an output register, so the next
// input word is accepted while it waits to be taken.
module fifo_with_wait_time_average #(
  parameter int DEPTH = fwta_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_removed_code,
  output logic [31:0]        out_wait_ticks,
  output logic [31:0]        out_average_wait
);

  fwta_pkg::fwta_cmd_t cmd;
  fwta_pkg::fwta_sts_t sts;

  fwta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwta_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_code          (in_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_code (out_removed_code),
    .out_wait_ticks   (out_wait_ticks),
    .out_average_wait (out_average_wait)
  );

endmodule

/* hdl/fwta_chk.sv */
module fwta_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_removed_code,
  input logic [31:0]        out_wait_ticks,
  input logic [31:0]        out_average_wait
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("result pending or input blocked after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fwta_pkg::ST_REMOVED) |->
      (out_removed_code == 0) && (out_wait_ticks == 0) && (out_average_wait == 0))
    else $error("non-remove result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_removed_code) && $stable(out_wait_ticks) && $stable(out_average_wait))
    else $error("stalled result changed");

endmodule

bind fifo_with_wait_time_average fwta_chk u_chk (.*);

/* verif/fifo_with_wait_time_average_test.sv */
module fifo_with_wait_time_average_test;

  localparam int DEPTH = fwta_pkg::DEPTH_DEFAULT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int SEGMENTS = 25;
  localparam int SEGMENT_WORDS = 40;
  localparam int DIRECTED_ROWS = 11;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] removed_code;
    logic [31:0] wait_ticks;
    logic [31:0] average_wait;
  } queue_result_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [31:0]   code;
    logic [4:0]    repeats;
    bit            typed;
    queue_result_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = fwta_pkg::KIND_TICK;
  logic signed [31:0] in_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_removed_code;
  logic [31:0]        out_wait_ticks;
  logic [31:0]        out_average_wait;

  bit            drv_typed = 1'b0;
  queue_result_t drv_want = '0;

  logic [31:0] model_codes [DEPTH];
  logic [31:0] model_stamps [DEPTH];
  int          model_head = 0;
  int          model_tail = 0;
  int          model_count = 0;
  logic [31:0] model_tick = '0;
  logic [31:0] model_wait_sum = '0;
  logic [31:0] model_inserts = '0;

  queue_result_t pending_results [$];
  stim_row_t     directed_rows [DIRECTED_ROWS];

  int errors = 0;
  int results_checked = 0;
  int words_sent = 0;
  int inserts_seen = 0;
  int removes_seen = 0;
  int drops_seen = 0;
  int empties_seen = 0;
  int burst_left = 0;

  logic [15:0] stall_pattern = 16'hFFFF;
  int          pattern_age = 0;

  fifo_with_wait_time_average #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_code         (in_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_removed_code(out_removed_code),
    .out_wait_ticks  (out_wait_ticks),
    .out_average_wait(out_average_wait)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic queue_result_t queue_model_step(input logic [1:0] kind,
                                                     input logic [31:0] code);
    queue_result_t r;
    logic [32:0]   sum;
    r = '0;
    r.status = fwta_pkg::ST_TICK;
    case (kind)
      fwta_pkg::KIND_TICK: begin
        model_tick = model_tick + 32'd1;
      end
      fwta_pkg::KIND_INSERT: begin
        if (model_count >= DEPTH) begin
          r.status = fwta_pkg::ST_FULL;
        end else begin
          model_codes[model_tail] = code;
          model_stamps[model_tail] = model_tick;
          model_tail = (model_tail == DEPTH - 1) ? 0 : model_tail + 1;
          model_count++;
          if (model_inserts != '1) begin
            model_inserts = model_inserts + 32'd1;
          end
          r.status = fwta_pkg::ST_INSERTED;
        end
      end
      fwta_pkg::KIND_REMOVE: begin
        if (model_count == 0) begin
          r.status = fwta_pkg::ST_EMPTY;
        end else begin
          r.removed_code = model_codes[model_head];
          r.wait_ticks = model_tick - model_stamps[model_head];
          model_head = (model_head == DEPTH - 1) ? 0 : model_head + 1;
          model_count--;
          sum = {1'b0, model_wait_sum} + {1'b0, r.wait_ticks};
          model_wait_sum = sum[32] ? '1 : sum[31:0];
          r.average_wait = (model_inserts != 0) ? model_wait_sum / model_inserts : '0;
          r.status = fwta_pkg::ST_REMOVED;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s of result %0d: got %h, expected %h",
             what, results_checked, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_monitor
    queue_result_t predicted;
    queue_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = queue_model_step(in_kind, in_code);
        pending_results.push_back(drv_typed ? drv_want : predicted);
        words_sent++;
        case (predicted.status)
          fwta_pkg::ST_INSERTED: inserts_seen++;
          fwta_pkg::ST_REMOVED:  removes_seen++;
          fwta_pkg::ST_FULL:     drops_seen++;
          fwta_pkg::ST_EMPTY:    empties_seen++;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("status of an unexpected word", 32'(out_status), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            report_mismatch("status", 32'(out_status), 32'(want.status));
          end
          if (out_removed_code !== want.removed_code) begin
            report_mismatch("removed code", out_removed_code, want.removed_code);
          end
          if (out_wait_ticks !== want.wait_ticks) begin
            report_mismatch("wait ticks", out_wait_ticks, want.wait_ticks);
          end
          if (out_average_wait !== want.average_wait) begin
            report_mismatch("average wait", out_average_wait, want.average_wait);
          end
          results_checked++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(3))
        0: stall_pattern = 16'hFFFF;
        1: stall_pattern = 16'($urandom);
        2: stall_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
        default: stall_pattern = 16'h00FF;
      endcase
      pattern_age = $urandom_range(20, 120);
    end else begin
      pattern_age--;
    end
    out_ready <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("no word moved for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_word(input logic [1:0] kind, input logic [31:0] code,
                           input bit typed, input queue_result_t want);
    pace_sender();
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_code <= code;
    drv_typed <= typed;
    drv_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [1:0] pick_kind(input traffic_mix_t mix);
    int roll;
    int insert_cut;
    int remove_cut;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        insert_cut = 55;
        remove_cut = 70;
      end
      MIX_DRAIN: begin
        insert_cut = 15;
        remove_cut = 70;
      end
      default: begin
        insert_cut = 35;
        remove_cut = 70;
      end
    endcase
    if (roll < insert_cut) begin
      return fwta_pkg::KIND_INSERT;
    end else if (roll < remove_cut) begin
      return fwta_pkg::KIND_REMOVE;
    end else if (roll < 95) begin
      return fwta_pkg::KIND_TICK;
    end
    return KIND_UNUSED;
  endfunction

  initial begin : stimulus
    traffic_mix_t mix;
    directed_rows[0] = '{fwta_pkg::KIND_REMOVE, 32'h0000_0000, 5'd1, 1'b1,
                         '{fwta_pkg::ST_EMPTY, 0, 0, 0}};
    directed_rows[1] = '{KIND_UNUSED, 32'hFFFF_FFFF, 5'd1, 1'b1,
                         '{fwta_pkg::ST_TICK, 0, 0, 0}};
    directed_rows[2] = '{fwta_pkg::KIND_TICK, 32'h8000_0000, 5'd1, 1'b1,
                         '{fwta_pkg::ST_TICK, 0, 0, 0}};
    directed_rows[3] = '{fwta_pkg::KIND_INSERT, 32'h7FFF_FFFF, 5'd1, 1'b1,
                         '{fwta_pkg::ST_INSERTED, 0, 0, 0}};
    directed_rows[4] = '{fwta_pkg::KIND_INSERT, 32'h8000_0000, 5'd1, 1'b1,
                         '{fwta_pkg::ST_INSERTED, 0, 0, 0}};
    directed_rows[5] = '{fwta_pkg::KIND_INSERT, 32'h0000_0100, 5'(DEPTH - 2), 1'b0, '0};
    directed_rows[6] = '{fwta_pkg::KIND_INSERT, 32'hFFFF_FFFF, 5'd1, 1'b1,
                         '{fwta_pkg::ST_FULL, 0, 0, 0}};
    directed_rows[7] = '{fwta_pkg::KIND_TICK, 32'h0000_0000, 5'd1, 1'b0, '0};
    directed_rows[8] = '{fwta_pkg::KIND_TICK, 32'h7FFF_FFFF, 5'd1, 1'b0, '0};
    directed_rows[9] = '{fwta_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 5'd1, 1'b0, '0};
    directed_rows[10] = '{fwta_pkg::KIND_REMOVE, 32'h0000_0000, 5'd1, 1'b0, '0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].repeats; r++) begin
        send_word(directed_rows[i].kind, directed_rows[i].code + 32'(r),
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end
    wait_for_results();

    for (int s = 0; s < SEGMENTS; s++) begin
      mix = traffic_mix_t'($urandom_range(2));
      for (int w = 0; w < SEGMENT_WORDS; w++) begin
        send_word(pick_kind(mix), $urandom, 1'b0, '0);
      end
      if (s == SEGMENTS / 2) begin
        wait_for_results();
      end
    end
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words sent and %0d results checked: %0d inserts, %0d drops when full,",
             words_sent, results_checked, inserts_seen, drops_seen);
    $display("%0d removes and %0d removes from an empty queue.", removes_seen, empties_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
